@@ hdl/fixed_block_pool_allocator_unit_macros.svh @@
// assertion helpers for the block pool allocator
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FBPA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpa assertion failed");
// next-cycle implication
`define FBPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbpa assertion failed");
`else
`define FBPA_ASSERT_IMP(label, ante, cons)
`define FBPA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hdl/fbpa_pkg.sv @@
package fbpa_pkg;

    // default pool capacity
    localparam int DEF_MAX_BLOCKS = 256;

    // field widths
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int CNT_CFG_W  = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_CNT_W  = $clog2(ADDR_W);

    // config register reset values
    localparam logic [ADDR_W-1:0]    RST_BASE  = '0;
    localparam logic [SIZE_W-1:0]    RST_SIZE  = 16'd64;
    localparam logic [CNT_CFG_W-1:0] RST_COUNT = 9'd256;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    typedef enum logic [1:0] {
        ACT_ALLOC,
        ACT_FREE,
        ACT_REINIT,
        ACT_NONE
    } action_t;

    typedef enum logic [2:0] {
        STAT_OK,
        STAT_EMPTY,
        STAT_BELOW,
        STAT_MISALIGNED,
        STAT_RANGE,
        STAT_FULL,
        STAT_DOUBLE
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP,
        S_ALLOC_RD,
        S_ALLOC_MUL,
        S_ALLOC_ADD,
        S_DIV,
        S_CHECK,
        S_SCAN,
        S_PUSH,
        S_DONE
    } fsm_t;

    // divider result bundle
    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] quotient;
        logic [SIZE_W-1:0] remainder;
    } div_res_t;

endpackage

@@ hdl/fbpa_ram.sv @@
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/fbpa_div.sv @@
module fbpa_div
    import fbpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ADDR_W-1:0] dividend,
    input  logic [SIZE_W-1:0] divisor,
    output div_res_t          res
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [ADDR_W-1:0]    quo_reg;
    logic [SIZE_W-1:0]    rem_reg;
    logic [SIZE_W-1:0]    dvs_reg;

    logic [SIZE_W:0]      shifted;
    logic                 ge;
    logic [SIZE_W:0]      diff;

    // one restoring step per cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[ADDR_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = shifted >= {1'b0, dvs_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(ADDR_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[ADDR_W-2:0], ge};
            rem_reg <= ge ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

@@ hdl/fixed_block_pool_allocator_unit.sv @@
// Fixed-size block pool allocator with a LIFO free list held in one RAM.
//
// Request channel s_*: s_tuser carries the action (allocate, free, reinit),
// s_tdata the address to free. Result channel m_*: m_tdata carries the
// granted address (zero unless an allocation succeeded), m_tuser the status.
// Config channel cfg_*: index 0 base address, 1 block size, 2 block count;
// writes are always taken and are meant for idle periods only.
//
// One request is handled at a time. Allocate reads the stack top, multiplies
// it by the block size and adds the base. Free starts a serial divider that
// produces index and remainder, then the double-free scan reads one stack
// entry per cycle through the RAM read port. Reinit rewrites every stack entry.
//
// After reset the stack RAM is filled by a sweep over every entry, with
// s_tready low. A finished result sits in an output register; the next
// request is accepted while it waits, and when m_tready is held low the
// following result waits inside the block until the register frees up.
module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request item
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ADDR_W-1:0]    s_tdata,   // [31:0] block_address
    input  logic [1:0]           s_tuser,   // [1:0] action
    // result item
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [ADDR_W-1:0]    m_tdata,   // [31:0] granted_address
    output logic [2:0]           m_tuser,   // [2:0] status
    // config writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    `include "fixed_block_pool_allocator_unit_macros.svh"

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int PW = AW + SIZE_W;
    localparam logic [CW-1:0] RST_DEPTH = CW'(MAX_BLOCKS < 256 ? MAX_BLOCKS : 256);

    fsm_t                 state_reg, state_next;
    logic [CW-1:0]        depth_reg;
    logic [AW-1:0]        sweep_reg;
    logic [CW-1:0]        scan_reg;
    logic                 rd_valid_reg;
    logic                 reinit_pend_reg;
    logic                 out_valid_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic [SIZE_W-1:0]    bsize_reg;
    logic [CNT_CFG_W-1:0] count_reg;

    logic [AW-1:0]        idx_reg;
    logic [PW-1:0]        prod_reg;
    logic [ADDR_W-1:0]    res_addr_reg;
    status_t              res_status_reg;
    logic [ADDR_W-1:0]    out_data_reg;
    status_t              out_user_reg;

    logic [CW-1:0]        eff_count;
    logic [SIZE_W-1:0]    eff_size;
    action_t              act;
    logic                 below;
    logic [ADDR_W-1:0]    offset;
    status_t              chk_status;
    logic                 scan_hit;
    logic                 scan_issue;
    logic                 sweep_last;
    logic                 out_load;
    logic                 div_start;
    div_res_t             div_res;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [AW-1:0]        ram_rdata;

    // effective count and block size
    always_comb
    begin
        if (count_reg == '0)
        begin
            eff_count = CW'(1);
        end
        else if (32'(count_reg) > 32'(MAX_BLOCKS))
        begin
            eff_count = CW'(MAX_BLOCKS);
        end
        else
        begin
            eff_count = CW'(count_reg);
        end
        eff_size = (bsize_reg == '0) ? SIZE_W'(1) : bsize_reg;
    end

    // request decode
    assign act    = action_t'(s_tuser);
    assign below  = s_tdata < base_reg;
    assign offset = s_tdata - base_reg;

    // free checks after the divide
    always_comb
    begin
        if (div_res.remainder != '0)
        begin
            chk_status = STAT_MISALIGNED;
        end
        else if (div_res.quotient >= 32'(eff_count))
        begin
            chk_status = STAT_RANGE;
        end
        else if (depth_reg >= eff_count)
        begin
            chk_status = STAT_FULL;
        end
        else
        begin
            chk_status = STAT_OK;
        end
    end

    assign scan_hit   = rd_valid_reg && (ram_rdata == idx_reg);
    assign sweep_last = sweep_reg == AW'(MAX_BLOCKS - 1);
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (act)
                        ACT_ALLOC:  state_next = (depth_reg == '0) ? S_DONE : S_ALLOC_RD;
                        ACT_FREE:   state_next = below ? S_DONE : S_DIV;
                        ACT_REINIT: state_next = S_SWEEP;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = reinit_pend_reg ? S_DONE : S_IDLE;
                end
            end
            S_ALLOC_RD:  state_next = S_ALLOC_MUL;
            S_ALLOC_MUL: state_next = S_ALLOC_ADD;
            S_ALLOC_ADD: state_next = S_DONE;
            S_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:     state_next = (chk_status == STAT_OK) ? S_SCAN : S_DONE;
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = S_DONE;
                end
                else if (!scan_issue && !rd_valid_reg)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:      state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = sweep_reg;
        ram_wdata  = sweep_reg;
        ram_raddr  = depth_reg[AW-1:0];
        div_start  = 1'b0;
        scan_issue = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready  = 1'b1;
                div_start = s_tvalid && (act == ACT_FREE) && !below;
            end
            S_SWEEP:
            begin
                ram_we = 1'b1;
            end
            S_SCAN:
            begin
                scan_issue = scan_reg < depth_reg;
                ram_raddr  = scan_reg[AW-1:0];
            end
            S_PUSH:
            begin
                ram_we    = 1'b1;
                ram_waddr = depth_reg[AW-1:0];
                ram_wdata = idx_reg;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign cfg_ready = 1'b1;

    // control registers and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            depth_reg       <= RST_DEPTH;
            sweep_reg       <= '0;
            scan_reg        <= '0;
            rd_valid_reg    <= 1'b0;
            reinit_pend_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            base_reg        <= RST_BASE;
            bsize_reg       <= RST_SIZE;
            count_reg       <= RST_COUNT;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= scan_issue;

            // config write
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_BASE:  base_reg  <= cfg_data;
                    CFG_SIZE:  bsize_reg <= cfg_data[SIZE_W-1:0];
                    CFG_COUNT: count_reg <= cfg_data[CNT_CFG_W-1:0];
                    default:   base_reg  <= base_reg;
                endcase
            end

            // stack depth and sweep
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && (act == ACT_ALLOC) && (depth_reg != '0))
                    begin
                        depth_reg <= depth_reg - 1'b1;
                    end
                    if (s_tvalid && (act == ACT_REINIT))
                    begin
                        depth_reg       <= eff_count;
                        sweep_reg       <= '0;
                        reinit_pend_reg <= 1'b1;
                    end
                end
                S_SWEEP:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_last)
                    begin
                        reinit_pend_reg <= 1'b0;
                    end
                end
                S_CHECK:
                begin
                    scan_reg <= '0;
                end
                S_SCAN:
                begin
                    if (scan_issue)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                S_PUSH:
                begin
                    depth_reg <= depth_reg + 1'b1;
                end
                default:
                begin
                    scan_reg <= scan_reg;
                end
            endcase

            // output register valid
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                res_addr_reg   <= '0;
                res_status_reg <= STAT_OK;
                if (act == ACT_ALLOC && depth_reg == '0)
                begin
                    res_status_reg <= STAT_EMPTY;
                end
                else if (act == ACT_FREE && below)
                begin
                    res_status_reg <= STAT_BELOW;
                end
            end
            S_ALLOC_MUL:
            begin
                prod_reg <= PW'(ram_rdata) * PW'(eff_size);
            end
            S_ALLOC_ADD:
            begin
                res_addr_reg <= base_reg + 32'(prod_reg);
            end
            S_CHECK:
            begin
                res_status_reg <= chk_status;
                idx_reg        <= div_res.quotient[AW-1:0];
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    res_status_reg <= STAT_DOUBLE;
                end
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
        if (out_load)
        begin
            out_data_reg <= res_addr_reg;
            out_user_reg <= res_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // free stack storage
    fbpa_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // offset divide for free requests
    fbpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (offset),
        .divisor  (eff_size),
        .res      (div_res)
    );

    // checks
    `FBPA_ASSERT_IMP(a_push_below_count, state_reg == S_PUSH, depth_reg < eff_count)
    `FBPA_ASSERT_NEXT(a_done_holds, (state_reg == S_DONE) && out_valid_reg && !m_tready,
        state_reg == S_DONE)
    `FBPA_ASSERT_IMP(a_grant_only_ok, out_valid_reg && (out_user_reg != STAT_OK),
        out_data_reg == '0)
    `FBPA_ASSERT_IMP(a_div_done_in_div, div_res.done, state_reg == S_DIV)

endmodule
